[sv/pbcd_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package pbcd_pkg;

  localparam int DIG_MAX = 18;
  localparam int DIGS_W  = 4 * DIG_MAX;
  localparam int NUM_W   = 64;
  localparam int INT_W   = 62;

  localparam logic [15:0]      SIGN_BIT = 16'h8000;
  localparam logic [15:0]      INDEF_HI = 16'hFFFF;
  localparam logic [NUM_W-1:0] INDEF_LO = 64'hC000_0000_0000_0000;

  typedef enum logic {
    CMD_DECODE = 1'b0,
    CMD_ENCODE = 1'b1
  } cmd_t;

  // Item travelling down the digit chain. num is the accumulator on decode
  // and the remainder still to be split into digits on encode.
  typedef struct packed {
    cmd_t              cmd;
    logic              neg;
    logic              bad;
    logic [NUM_W-1:0]  num;
    logic [DIGS_W-1:0] digs;
  } pbcd_item_t;

  function automatic logic [NUM_W-1:0] pbcd_pow10(input int k);
    logic [NUM_W-1:0] p;
    p = 64'd1;
    for (int i = 0; i < k; i++) begin
      p = p * 64'd10;
    end
    return p;
  endfunction

endpackage
`default_nettype wire

[sv/pbcd_if.sv]
`timescale 1ns / 1ps
`default_nettype none
interface pbcd_in_if;
  logic               valid;
  logic               ready;
  logic               cmd;
  logic [63:0]        bcd_digits_low;
  logic [15:0]        bcd_word_high;
  logic signed [63:0] int_in;
  logic               upstream_invalid;

  modport source (output valid, output cmd, output bcd_digits_low, output bcd_word_high,
                  output int_in, output upstream_invalid, input ready);
  modport sink   (input valid, input cmd, input bcd_digits_low, input bcd_word_high,
                  input int_in, input upstream_invalid, output ready);
endinterface

interface pbcd_out_if;
  logic               valid;
  logic               ready;
  logic signed [61:0] int_out;
  logic [63:0]        bcd_low_out;
  logic [15:0]        bcd_high_out;
  logic               invalid;

  modport source (output valid, output int_out, output bcd_low_out, output bcd_high_out,
                  output invalid, input ready);
  modport sink   (input valid, input int_out, input bcd_low_out, input bcd_high_out,
                  input invalid, output ready);
endinterface
`default_nettype wire

[sv/pbcd_entry.sv]
`timescale 1ns / 1ps
`default_nettype none
module pbcd_entry
  import pbcd_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  pbcd_in_if.sink         din,
  output logic            valid,
  output pbcd_item_t      item,
  input  wire logic       down_ready
);

  pbcd_item_t       item_next;
  logic [NUM_W-1:0] neg_mag;

  assign din.ready = !valid || down_ready;
  assign neg_mag   = 64'd0 - $unsigned(din.int_in);

  always_comb begin
    item_next = '0;
    if (din.cmd == CMD_ENCODE) begin
      item_next.cmd  = CMD_ENCODE;
      item_next.neg  = din.int_in[63];
      // most negative input wraps to 2^63 and fails the range check later
      item_next.num  = din.int_in[63] ? neg_mag : $unsigned(din.int_in);
      item_next.bad  = din.upstream_invalid;
      item_next.digs = '0;
    end else begin
      item_next.cmd  = CMD_DECODE;
      item_next.neg  = |(din.bcd_word_high & SIGN_BIT);
      item_next.num  = '0;
      item_next.bad  = 1'b0;
      item_next.digs = {din.bcd_word_high[7:0], din.bcd_digits_low};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (din.ready) begin
      valid <= din.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (din.ready && din.valid) begin
      item <= item_next;
    end
  end

endmodule
`default_nettype wire

[sv/pbcd_cell.sv]
`timescale 1ns / 1ps
`default_nettype none
module pbcd_cell
  import pbcd_pkg::*;
#(
  parameter int K = 0
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       up_valid,
  input  wire pbcd_item_t up_item,
  output logic            up_ready,
  output logic            valid,
  output pbcd_item_t      item,
  input  wire logic       down_ready
);

  pbcd_item_t       item_next;
  logic [NUM_W:0]   diff [1:10];
  logic [3:0]       q;
  logic [NUM_W-1:0] rem;

  assign up_ready = !valid || down_ready;

  // trial subtraction of every multiple of 10^K; the tenth flags overflow
  for (genvar d = 1; d <= 10; d++) begin : g_trial
    localparam logic [NUM_W-1:0] SUBV = pbcd_pow10(K) * 64'(d);
    assign diff[d] = {1'b0, up_item.num} - {1'b0, SUBV};
  end

  always_comb begin
    q   = 4'd0;
    rem = up_item.num;
    for (int d = 1; d <= 10; d++) begin
      if (!diff[d][NUM_W]) begin
        q   = 4'(d);
        rem = diff[d][NUM_W-1:0];
      end
    end
  end

  always_comb begin
    item_next = up_item;
    if (up_item.cmd == CMD_DECODE) begin
      item_next.num = (up_item.num << 3) + (up_item.num << 1)
                    + 64'(up_item.digs[4*K +: 4]);
    end else begin
      item_next.num           = rem;
      item_next.digs[4*K +: 4] = q;
      if (q == 4'd10) begin
        item_next.bad = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (up_ready) begin
      valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      item <= item_next;
    end
  end

endmodule
`default_nettype wire

[sv/packed_bcd18_convert_core.sv]
// Packed BCD <-> integer converter, one digit cell per BCD digit, MSD first.
// Registers between input transfer and result: the entry register, one
// register per digit cell and the output register.
// Throughput: one item per cycle; every stage stalls only when the one after
// it is full and blocked.
// Reset clears all stage valid flags; the chain is empty after reset.
`timescale 1ns / 1ps
`default_nettype none
module packed_bcd18_convert_core
  import pbcd_pkg::*;
#(
  parameter int DIGITS = 18
) (
  input  wire logic clk,
  input  wire logic rst,
  pbcd_in_if.sink   din,
  pbcd_out_if.source dout
);

  pbcd_item_t chain_item  [0:DIGITS];
  logic       chain_valid [0:DIGITS];
  logic       chain_ready [0:DIGITS];

  pbcd_item_t         last;
  logic               out_valid;
  logic signed [61:0] int_out_next;
  logic [63:0]        low_next;
  logic [15:0]        high_next;
  logic               inv_next;
  logic [INT_W-1:0]   mag;

  pbcd_entry u_entry (
    .clk        (clk),
    .rst        (rst),
    .din        (din),
    .valid      (chain_valid[0]),
    .item       (chain_item[0]),
    .down_ready (chain_ready[0])
  );

  for (genvar i = 0; i < DIGITS; i++) begin : g_cell
    pbcd_cell #(
      .K (DIGITS - 1 - i)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .up_valid   (chain_valid[i]),
      .up_item    (chain_item[i]),
      .up_ready   (chain_ready[i]),
      .valid      (chain_valid[i+1]),
      .item       (chain_item[i+1]),
      .down_ready (chain_ready[i+1])
    );
  end

  assign chain_ready[DIGITS] = !out_valid || dout.ready;
  assign last                = chain_item[DIGITS];
  assign mag                 = last.num[INT_W-1:0];

  always_comb begin
    int_out_next = '0;
    low_next     = '0;
    high_next    = '0;
    inv_next     = 1'b0;
    if (last.cmd == CMD_DECODE) begin
      int_out_next = last.neg ? $signed(62'd0 - mag) : $signed(mag);
    end else if (last.bad) begin
      low_next  = INDEF_LO;
      high_next = INDEF_HI;
      inv_next  = 1'b1;
    end else begin
      low_next  = last.digs[63:0];
      high_next = {8'd0, last.digs[DIGS_W-1:64]} | (last.neg ? SIGN_BIT : 16'd0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (chain_ready[DIGITS]) begin
      out_valid <= chain_valid[DIGITS];
    end
  end

  always_ff @(posedge clk) begin
    if (chain_ready[DIGITS] && chain_valid[DIGITS]) begin
      dout.int_out      <= int_out_next;
      dout.bcd_low_out  <= low_next;
      dout.bcd_high_out <= high_next;
      dout.invalid      <= inv_next;
    end
  end

  assign dout.valid = out_valid;

endmodule
`default_nettype wire
